// ===== sv/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int WILD_W     = 16;
    localparam int LEN_CFG_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO = 3'd0,
        REG_PAT_HI = 3'd1,
        REG_WILD   = 3'd2,
        REG_LEN    = 3'd3,
        REG_BASE   = 3'd4
    } t_reg_idx;

    // pattern bytes and wildcard bits as seen by the compare unit
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pat_hi;
        logic [CFG_DATA_W-1:0] pat_lo;
        logic [WILD_W-1:0]     wild;
    } t_pat_cfg;

endpackage

// ===== sv/wbps_if.sv =====
// ----------------------------------------------------------------------------
// wbps_if
// Valid/ready channels of the scanner: byte input, result output, config.
// ----------------------------------------------------------------------------
interface wbps_in_if;
    logic                        valid;
    logic                        ready;
    logic [wbps_pkg::BYTE_W-1:0] data_byte;
    logic                        region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [wbps_pkg::ADDR_W-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

interface wbps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wbps_pkg::CFG_IDX_W-1:0]  index;
    logic [wbps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/wildcard_byte_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Streams a memory region byte by byte and reports the first wildcard match.
// ----------------------------------------------------------------------------
// Takes one byte per clock, sustained, for as long as results are taken. A
// byte is registered into the sliding window and byte count on the cycle it
// is accepted; the window is then compared against the pattern and the
// result register loads once free, so a result passes both registers after
// the byte that completes the match (or the region's last byte). Input stalls
// only when a result waits in the output register and the next result is
// already formed behind it. One result per region: found with the address
// of the first complete match, or not-found on the last byte. Bytes after a
// match are dropped until the region ends. Configuration must be written
// while the scanner is idle.
module wildcard_byte_pattern_scanner_unit #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_BITS  = wbps_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wbps_in_if.sink            i_data,
    wbps_out_if.source         o_result,
    wbps_cfg_if.sink           i_cfg
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // configuration
    logic [wbps_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [wbps_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [wbps_pkg::WILD_W-1:0]     r_wild;
    logic [wbps_pkg::LEN_CFG_W-1:0]  r_len;
    logic [wbps_pkg::ADDR_W-1:0]     r_base;

    // region state, updated on accept
    logic [PATTERN_MAX-1:0][wbps_pkg::BYTE_W-1:0] r_win;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] r_off;
    logic                  r_ge;
    logic                  r_fresh;
    logic                  r_done;

    // item under compare
    logic r_s1_valid;
    logic r_s1_last;
    logic r_s1_active;

    // result register
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [wbps_pkg::ADDR_W-1:0] r_out_addr;

    logic [LEN_W-1:0]      used_len;
    logic [COUNT_BITS-1:0] cnt_base;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] n_off;
    logic                  n_ge;
    logic [PATTERN_MAX-1:0][wbps_pkg::BYTE_W-1:0] n_win;
    logic                  win_hit;
    logic                  hit_raw;
    logic                  s1_hit;
    logic                  emit;
    logic                  s1_move;
    logic                  accept;
    logic                  done_eff;
    wbps_pkg::t_pat_cfg    pat_cfg;

    always_comb begin
        if (r_len == '0) begin
            used_len = LEN_W'(1);
        end else if (r_len > wbps_pkg::LEN_CFG_W'(PATTERN_MAX)) begin
            used_len = LEN_W'(PATTERN_MAX);
        end else begin
            used_len = LEN_W'(r_len);
        end
    end

    assign pat_cfg = '{pat_hi: r_pat_hi, pat_lo: r_pat_lo, wild: r_wild};

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .i_win (r_win),
        .i_pat (pat_cfg),
        .i_len (used_len),
        .o_hit (win_hit)
    );

    assign hit_raw = r_ge & win_hit;
    assign s1_hit  = r_s1_valid & r_s1_active & hit_raw;
    assign emit    = r_s1_valid & r_s1_active & (hit_raw | r_s1_last);
    assign s1_move = !emit || !r_out_valid || o_result.ready;
    assign accept  = i_data.valid & s1_move;

    // match status seen by the incoming byte, including the byte ahead of it
    assign done_eff = (r_s1_valid && r_s1_last) ? 1'b0 : (r_done | s1_hit);

    // saturating count; the start offset is formed here to keep the add short
    assign cnt_base = r_fresh ? '0 : r_cnt;
    assign n_cnt    = (&cnt_base) ? cnt_base : cnt_base + COUNT_BITS'(1);
    assign n_ge     = n_cnt >= COUNT_BITS'(used_len);
    assign n_off    = n_cnt - COUNT_BITS'(used_len);

    // newest byte enters slot 0
    always_comb begin
        n_win[0] = i_data.data_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign i_data.ready           = s1_move;
    assign i_cfg.ready            = 1'b1;
    assign o_result.valid         = r_out_valid;
    assign o_result.found         = r_out_found;
    assign o_result.match_address = r_out_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_wild      <= '0;
            r_len       <= wbps_pkg::LEN_CFG_W'(1);
            r_base      <= '0;
            r_fresh     <= 1'b1;
            r_done      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s1_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    wbps_pkg::REG_PAT_LO: r_pat_lo <= i_cfg.data;
                    wbps_pkg::REG_PAT_HI: r_pat_hi <= i_cfg.data;
                    wbps_pkg::REG_WILD:   r_wild   <= i_cfg.data[wbps_pkg::WILD_W-1:0];
                    wbps_pkg::REG_LEN:    r_len    <= i_cfg.data[wbps_pkg::LEN_CFG_W-1:0];
                    wbps_pkg::REG_BASE:   r_base   <= i_cfg.data;
                    default: ;
                endcase
            end

            if (r_s1_valid && s1_move) begin
                r_done <= r_s1_last ? 1'b0 : (r_done | s1_hit);
            end

            if (accept) begin
                r_s1_valid  <= 1'b1;
                r_s1_last   <= i_data.region_end;
                r_s1_active <= !done_eff;
                r_fresh     <= i_data.region_end;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (!r_out_valid || o_result.ready) begin
                r_out_valid <= emit;
            end
        end

        // payload, no reset needed
        if (accept && !done_eff) begin
            r_win <= n_win;
            r_cnt <= n_cnt;
            r_off <= n_off;
            r_ge  <= n_ge;
        end
        if (!r_out_valid || o_result.ready) begin
            r_out_found <= hit_raw;
            r_out_addr  <= hit_raw ? r_base + wbps_pkg::ADDR_W'(r_off) : '0;
        end
    end

endmodule

// ===== sv/wbps_match.sv =====
// ----------------------------------------------------------------------------
// wbps_match
// Parallel wildcard compare of the byte window against the pattern.
// ----------------------------------------------------------------------------
module wbps_match #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic [PATTERN_MAX-1:0][wbps_pkg::BYTE_W-1:0] i_win,
    input  wbps_pkg::t_pat_cfg                           i_pat,
    input  logic [LEN_W-1:0]                             i_len,
    output logic                                         o_hit
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [2*wbps_pkg::CFG_DATA_W-1:0] pat_all;
    logic [PATTERN_MAX-1:0]            byte_ok;
    logic [PATTERN_MAX-1:0][IDX_W-1:0] win_idx;

    assign pat_all = {i_pat.pat_hi, i_pat.pat_lo};

    // pattern byte k lines up with window slot len-1-k (newest byte in slot 0)
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            win_idx[k] = IDX_W'(i_len - LEN_W'(k) - LEN_W'(1));
            byte_ok[k] = 1'b1;
            if (LEN_W'(k) < i_len && !i_pat.wild[k]) begin
                byte_ok[k] = (i_win[win_idx[k]] == pat_all[wbps_pkg::BYTE_W*k +: wbps_pkg::BYTE_W]);
            end
        end
    end

    assign o_hit = &byte_ok;

endmodule

// ===== sv/wbps_chk.sv =====
// ----------------------------------------------------------------------------
// wbps_chk
// Port-level checks on the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wbps_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_found,
    input logic [wbps_pkg::ADDR_W-1:0] i_out_addr
);

    logic in_acc;
    assign in_acc = i_in_valid & i_in_ready;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_found)
            && $stable(i_out_addr))
        else $error("result changed while stalled");

    // not-found results carry a zero address
    a_nf_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_addr == '0)
        else $error("not-found result with nonzero address");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a fresh result needs an item accepted ahead of the window and result registers
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("result without a preceding item");

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_chk u_wbps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_data.valid),
    .i_in_ready  (i_data.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_found (o_result.found),
    .i_out_addr  (o_result.match_address)
);
